### rtl/voice_satellite_mode_fsm_assert.svh
// Assertion macros used by the mode controller top level.
`ifndef VOICE_SATELLITE_MODE_FSM_ASSERT_SVH
`define VOICE_SATELLITE_MODE_FSM_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define VSM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mode controller assertion failed");

// Consequent checked in the cycle after the antecedent.
`define VSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mode controller assertion failed");

`endif

### rtl/vsm_pkg.sv
// Types, codes and reset constants of the voice satellite mode controller.
package vsm_pkg;

  localparam int unsigned TIME_BITS_DEF = 48;
  localparam int unsigned CFG_W         = 32;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [31:0] AMP_DEAF_RST    = 32'd200000;
  localparam logic [31:0] WAKE_ACK_RST    = 32'd5000000;
  localparam logic [31:0] CAPTURE_MAX_RST = 32'd120000000;

  typedef enum logic [3:0] {
    ModeBoot      = 4'd0,
    ModeNoNetwork = 4'd1,
    ModeNoDaemon  = 4'd2,
    ModeFault     = 4'd3,
    ModeIdle      = 4'd4,
    ModeListen    = 4'd5,
    ModeThink     = 4'd6,
    ModeSpeak     = 4'd7,
    ModeApproval  = 4'd8,
    ModeCapture   = 4'd9
  } mode_e;

  typedef enum logic [3:0] {
    OpNetUp         = 4'd0,
    OpNetDown       = 4'd1,
    OpWake          = 4'd2,
    OpVoice         = 4'd3,
    OpPlayStart     = 4'd4,
    OpPlayEnd       = 4'd5,
    OpMicDead       = 4'd6,
    OpLinkUp        = 4'd7,
    OpLinkDown      = 4'd8,
    OpLinkRejected  = 4'd9,
    OpUnprovisioned = 4'd10,
    OpRemote        = 4'd11,
    OpCapStart      = 4'd12,
    OpCapStop       = 4'd13,
    OpTick          = 4'd14,
    OpIgnored       = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    RemIdle      = 3'd0,
    RemListening = 3'd1,
    RemThinking  = 3'd2,
    RemApproval  = 3'd3,
    RemSpeaking  = 3'd4,
    RemUnknown   = 3'd5
  } remote_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgAmpDeaf    = 2'd0,
    CfgWakeAck    = 2'd1,
    CfgCaptureMax = 2'd2,
    CfgBargeIn    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {UplNone  = 2'd0, UplOpen  = 2'd1, UplClose   = 2'd2} uplink_e;
  typedef enum logic [1:0] {GateNone = 2'd0, GateOn   = 2'd1, GateOff    = 2'd2} gate_e;
  typedef enum logic [1:0] {AmpNone  = 2'd0, AmpRaise = 2'd1, AmpLower   = 2'd2} amp_e;
  typedef enum logic [1:0] {ArmNone  = 2'd0, ArmArm   = 2'd1, ArmDisarm  = 2'd2} arm_e;
  typedef enum logic [1:0] {FlashNone = 2'd0, FlashGreen = 2'd1, FlashWhite = 2'd2} flash_e;
  typedef enum logic [1:0] {PostNone = 2'd0, PostSpeech = 2'd1, PostBargeIn = 2'd2} post_e;

  typedef struct packed {
    logic [31:0] amp_deaf;
    logic [31:0] wake_ack;
    logic [31:0] capture_max;
    logic        barge_in;
  } cfg_t;

  typedef struct packed {
    mode_e mode;
    logic  address_held;
    logic  link_held;
    logic  session_acked;
  } flags_t;

  typedef struct packed {
    mode_e   mode;
    logic    mode_changed;
    uplink_e uplink;
    gate_e   gate;
    amp_e    amp;
    logic    flush;
    arm_e    arm;
    flash_e  flash;
    post_e   post;
  } res_t;

endpackage

### rtl/vsm_if.sv
// Valid/ready channel interfaces for event words and result words.
interface vsm_evt_if #(
  parameter int unsigned TIME_BITS = vsm_pkg::TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [3:0]           operation;
  logic [2:0]           remote_code;
  logic [TIME_BITS-1:0] now_us;
  logic [31:0]          amp_age_us;

  modport source (output valid, operation, remote_code, now_us, amp_age_us, input ready);
  modport sink (input valid, operation, remote_code, now_us, amp_age_us, output ready);
endinterface

interface vsm_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic       mode_changed;
  logic [1:0] uplink_cmd;
  logic [1:0] gate_cmd;
  logic [1:0] amp_cmd;
  logic       playout_flush;
  logic [1:0] wake_arm_cmd;
  logic [1:0] flash_color;
  logic [1:0] post_event;

  modport source (output valid, mode, mode_changed, uplink_cmd, gate_cmd, amp_cmd,
                  playout_flush, wake_arm_cmd, flash_color, post_event, input ready);
  modport sink (input valid, mode, mode_changed, uplink_cmd, gate_cmd, amp_cmd,
                playout_flush, wake_arm_cmd, flash_color, post_event, output ready);
endinterface

### rtl/voice_satellite_mode_fsm.sv
// Top level of the voice satellite mode controller.
// Usage: event words arrive on the evt_i channel (operation, remote code, time
// stamp and amplifier age) and each one yields exactly one result word on res_o
// with the new mode, a mode-change flag and the driver commands.
// An accepted event word is registered in the input register, then decided against
// the held mode, flags and entry time; the result word is loaded into the output
// register once that register is empty or being read by the receiver.
// Throughput is one word per cycle while the receiver takes results: the decision
// for a word and the state update it makes happen in the same cycle, so the next word sees it at once.
// When the receiver stalls, the result holds in the output register, the input
// register fills and only then is evt_i.ready dropped; nothing is lost.
// Reset clears the mode to boot, all flags and the entry time, and loads the
// default deaf, wake-acknowledge and capture limits with barge-in disabled.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user
// must write it while no word is in flight, as the block does not enforce this; an
// index picks the register in the order deaf time, wake-acknowledge time, capture limit, barge-in enable.
module voice_satellite_mode_fsm #(
  parameter int unsigned TIME_BITS = vsm_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  vsm_evt_if.sink                         evt_i,
  vsm_res_if.source                       res_o,
  input  logic                            cfg_we_i,
  input  logic [vsm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vsm_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import vsm_pkg::*;

  `include "voice_satellite_mode_fsm_assert.svh"

  cfg_t                 cfg_q;
  logic                 in_valid_q;
  op_e                  op_q;
  remote_e              remote_q;
  logic [TIME_BITS-1:0] now_q;
  logic [31:0]          age_q;
  flags_t               flags_q, flags_d;
  logic [TIME_BITS-1:0] entry_q, entry_d;
  logic                 out_valid_q;
  res_t                 res_q, res_d;
  logic                 advance;
  logic                 in_take;

  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || advance;
  assign in_take     = evt_i.valid && evt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amp_deaf    <= AMP_DEAF_RST;
      cfg_q.wake_ack    <= WAKE_ACK_RST;
      cfg_q.capture_max <= CAPTURE_MAX_RST;
      cfg_q.barge_in    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgAmpDeaf:    cfg_q.amp_deaf    <= cfg_wdata_i;
        CfgWakeAck:    cfg_q.wake_ack    <= cfg_wdata_i;
        CfgCaptureMax: cfg_q.capture_max <= cfg_wdata_i;
        CfgBargeIn:    cfg_q.barge_in    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q     <= op_e'(evt_i.operation);
      remote_q <= remote_e'(evt_i.remote_code);
      now_q    <= evt_i.now_us;
      age_q    <= evt_i.amp_age_us;
    end
  end

  vsm_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .flags_q_i (flags_q),
    .entry_q_i (entry_q),
    .cfg_i     (cfg_q),
    .op_i      (op_q),
    .remote_i  (remote_q),
    .now_i     (now_q),
    .age_i     (age_q),
    .flags_d_o (flags_d),
    .entry_d_o (entry_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q.mode          <= ModeBoot;
      flags_q.address_held  <= 1'b0;
      flags_q.link_held     <= 1'b0;
      flags_q.session_acked <= 1'b0;
      entry_q               <= '0;
      out_valid_q           <= 1'b0;
    end else begin
      if (advance) begin
        flags_q <= flags_d;
        entry_q <= entry_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.mode          = res_q.mode;
  assign res_o.mode_changed  = res_q.mode_changed;
  assign res_o.uplink_cmd    = res_q.uplink;
  assign res_o.gate_cmd      = res_q.gate;
  assign res_o.amp_cmd       = res_q.amp;
  assign res_o.playout_flush = res_q.flush;
  assign res_o.wake_arm_cmd  = res_q.arm;
  assign res_o.flash_color   = res_q.flash;
  assign res_o.post_event    = res_q.post;

  `VSM_ASSERT_NEXT(a_fault_absorbs, flags_q.mode == ModeFault, flags_q.mode == ModeFault)
  `VSM_ASSERT_NEXT(a_result_tracks_mode, advance, res_q.mode == flags_q.mode)
  `VSM_ASSERT_NEXT(a_entry_on_change, advance && res_d.mode_changed,
                   entry_q == $past(now_q))
  `VSM_ASSERT_NEXT(a_link_down_clears, advance && op_q == OpLinkDown && flags_q.mode != ModeFault,
                   !flags_q.link_held)

endmodule

### rtl/vsm_step.sv
// Next-mode decision and driver commands for one event word.
module vsm_step #(
  parameter int unsigned TIME_BITS = vsm_pkg::TIME_BITS_DEF
) (
  input  vsm_pkg::flags_t       flags_q_i,
  input  logic [TIME_BITS-1:0]  entry_q_i,
  input  vsm_pkg::cfg_t         cfg_i,
  input  vsm_pkg::op_e          op_i,
  input  vsm_pkg::remote_e      remote_i,
  input  logic [TIME_BITS-1:0]  now_i,
  input  logic [31:0]           age_i,
  output vsm_pkg::flags_t       flags_d_o,
  output logic [TIME_BITS-1:0]  entry_d_o,
  output vsm_pkg::res_t         res_o
);
  import vsm_pkg::*;

  function automatic logic talking(mode_e m);
    return (m == ModeListen) || (m == ModeThink) || (m == ModeSpeak) || (m == ModeApproval);
  endfunction

  logic [TIME_BITS-1:0] elapsed;
  logic                 wake_expired;
  logic                 capture_expired;
  mode_e                from_mode;
  mode_e                to_mode;
  logic                 moved;
  flash_e               flash;
  post_e                post;

  assign elapsed         = now_i - entry_q_i;
  assign wake_expired    = elapsed > TIME_BITS'(cfg_i.wake_ack);
  assign capture_expired = elapsed > TIME_BITS'(cfg_i.capture_max);
  assign from_mode       = flags_q_i.mode;

  // Next state.
  always_comb begin
    flags_t nxt;
    nxt   = flags_q_i;
    flash = FlashNone;
    post  = PostNone;
    if (from_mode != ModeFault) begin
      case (op_i)
        OpNetUp: begin
          nxt.address_held = 1'b1;
          if (from_mode == ModeBoot || from_mode == ModeNoNetwork) begin
            nxt.mode = ModeNoDaemon;
          end
        end
        OpNetDown: begin
          nxt.address_held = 1'b0;
          nxt.link_held    = 1'b0;
          nxt.mode         = ModeNoNetwork;
        end
        OpWake: begin
          if (flags_q_i.link_held && from_mode == ModeIdle) begin
            nxt.mode = ModeListen;
          end
        end
        OpVoice: begin
          if (age_i >= cfg_i.amp_deaf) begin
            if (from_mode != ModeSpeak) begin
              if (talking(from_mode)) begin
                post = PostSpeech;
              end
            end else if (cfg_i.barge_in) begin
              flash    = FlashWhite;
              post     = PostBargeIn;
              nxt.mode = ModeListen;
            end
          end
        end
        OpPlayStart: begin
          if (talking(from_mode)) begin
            nxt.mode = ModeSpeak;
          end
        end
        OpPlayEnd: begin
          if (from_mode == ModeSpeak) begin
            nxt.mode = ModeListen;
          end
        end
        OpMicDead, OpLinkRejected, OpUnprovisioned: begin
          nxt.mode = ModeFault;
        end
        OpLinkUp: begin
          if (!flags_q_i.link_held) begin
            flash = FlashGreen;
          end
          nxt.link_held = 1'b1;
          if (!talking(from_mode)) begin
            nxt.mode = ModeIdle;
          end
        end
        OpLinkDown: begin
          nxt.link_held = 1'b0;
          nxt.mode      = flags_q_i.address_held ? ModeNoDaemon : ModeNoNetwork;
        end
        OpRemote: begin
          if (talking(from_mode)) begin
            case (remote_i)
              RemIdle: begin
                if (flags_q_i.session_acked) begin
                  nxt.mode = ModeIdle;
                end
              end
              RemListening: begin
                nxt.session_acked = 1'b1;
                nxt.mode          = ModeListen;
              end
              RemThinking: nxt.mode = ModeThink;
              RemApproval: nxt.mode = ModeApproval;
              default: ;
            endcase
          end
        end
        OpCapStart: begin
          if (from_mode == ModeIdle) begin
            nxt.mode = ModeCapture;
          end
        end
        OpCapStop: begin
          if (from_mode == ModeCapture) begin
            nxt.mode = ModeIdle;
          end
        end
        OpTick: begin
          if (from_mode == ModeListen && !flags_q_i.session_acked && wake_expired) begin
            nxt.mode = ModeIdle;
          end else if (from_mode == ModeCapture && capture_expired) begin
            nxt.mode = ModeIdle;
          end
        end
        default: ;
      endcase
    end
    // A conversation that starts afresh has not yet been acknowledged.
    if (nxt.mode != from_mode && talking(nxt.mode) && !talking(from_mode)) begin
      nxt.session_acked = 1'b0;
    end
    flags_d_o = nxt;
  end

  assign to_mode   = flags_d_o.mode;
  assign moved     = to_mode != from_mode;
  assign entry_d_o = moved ? now_i : entry_q_i;

  // Commands from leaving the old mode, then entering the new one.
  always_comb begin
    res_t r;
    r              = '0;
    r.mode         = to_mode;
    r.mode_changed = moved;
    r.uplink       = UplNone;
    r.gate         = GateNone;
    r.amp          = AmpNone;
    r.arm          = ArmNone;
    r.flash        = flash;
    r.post         = post;
    if (moved) begin
      if (from_mode == ModeCapture) begin
        r.uplink = UplClose;
        r.arm    = ArmArm;
      end
      if (talking(from_mode) && !talking(to_mode)) begin
        r.uplink = UplClose;
        r.amp    = AmpLower;
        r.flush  = 1'b1;
        r.arm    = ArmArm;
      end
      if (to_mode == ModeSpeak) begin
        r.gate = GateOn;
      end else if (from_mode == ModeSpeak) begin
        r.gate = GateOff;
      end
      if (to_mode == ModeCapture) begin
        r.arm    = ArmDisarm;
        r.gate   = GateOff;
        r.uplink = UplOpen;
      end
      if (talking(to_mode) && !talking(from_mode)) begin
        r.arm    = ArmDisarm;
        r.uplink = UplOpen;
        r.flush  = 1'b1;
        r.amp    = AmpRaise;
      end
    end
    res_o = r;
  end

endmodule
